[design/iclm_pkg.sv]
// shared types and constants for the idle-count cpu load meter
`timescale 1ns / 1ps

package iclm_pkg;

   localparam int unsigned DATA_W = 32;  // idle delta, baseline, window count
   localparam int unsigned PCT_W  = 8;   // reported percentages
   localparam int unsigned HIST_W = 7;   // one ring entry
   localparam int unsigned QUO_W  = 7;   // every quotient here stays below 128
   localparam int unsigned NUM_W  = DATA_W + QUO_W;  // holds delta * 100

   localparam logic [PCT_W-1:0] PCT_FULL = 8'd100;
   localparam logic [PCT_W-1:0] PCT_NONE = 8'd255;

   // divider request and status
   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  numer;
      logic [DATA_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

[design/idle_count_cpu_load_meter_core.sv]
// top level of the idle-count cpu load meter: sequencer, history ring and result register
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_ready   req_idle_delta[31:0]
//   rsp      out  rsp_valid/rsp_ready   rsp_load_instant, rsp_load_average,
//                                       rsp_window_total, rsp_idle_reference
//
// one beat at a time: req_ready is high only while the sequencer is idle
// seeding or idle-never-ran beats go from the scale and check steps straight to the final step
// a computed beat runs the 7-step shared divider for the busy quotient when delta is below
// baseline, and once the ring is full, the one-entry-per-cycle ring sweep and the divider again
// synchronous active-high reset clears control state; the ring itself is not cleared
// a result waiting on rsp_ready holds the next beat in the final step only
`timescale 1ns / 1ps

module idle_count_cpu_load_meter_core #(
   parameter int unsigned AVG_WINDOWS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [iclm_pkg::DATA_W-1:0]  req_idle_delta,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [iclm_pkg::PCT_W-1:0]   rsp_load_instant,
   output logic [iclm_pkg::PCT_W-1:0]   rsp_load_average,
   output logic [iclm_pkg::DATA_W-1:0]  rsp_window_total,
   output logic [iclm_pkg::DATA_W-1:0]  rsp_idle_reference
);
   import iclm_pkg::*;

   localparam int unsigned IDX_W = (AVG_WINDOWS > 1) ? $clog2(AVG_WINDOWS) : 1;
   localparam int unsigned CNT_W = $clog2(AVG_WINDOWS + 1);
   localparam int unsigned SUM_W = $clog2(127 * AVG_WINDOWS + 1);
   localparam int unsigned SCL_W = DATA_W + 5;  // holds 21 * baseline

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCALE,
      S_CHECK,
      S_CLASS,
      S_DIVQ,
      S_RING,
      S_SUM,
      S_SUMEND,
      S_DIVA,
      S_DIVAW,
      S_EMIT
   } state_type;

   state_type          state_ff;

   // architectural state
   logic [DATA_W-1:0]  baseline_ff;
   logic [PCT_W-1:0]   instant_ff;
   logic [PCT_W-1:0]   average_ff;
   logic [DATA_W-1:0]  windows_ff;
   logic [IDX_W-1:0]   pos_ff;
   logic [CNT_W-1:0]   fill_ff;

   // working registers for one beat
   logic [DATA_W-1:0]  delta_ff;
   logic [SCL_W-1:0]   sdelta_ff;   // 20 * delta
   logic [SCL_W-1:0]   sbase_ff;    // 21 * baseline
   logic [NUM_W-1:0]   prod_ff;     // 100 * delta
   logic [PCT_W-1:0]   busy_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [SUM_W-1:0]   acc_ff;

   // result register
   logic               rsp_valid_ff;
   logic [PCT_W-1:0]   rsp_instant_ff;
   logic [PCT_W-1:0]   rsp_average_ff;
   logic [DATA_W-1:0]  rsp_total_ff;
   logic [DATA_W-1:0]  rsp_ref_ff;

   // history ring
   logic [HIST_W-1:0]  ring_mem [AVG_WINDOWS];
   logic [HIST_W-1:0]  rd_ff;
   logic               ring_wr;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic [SCL_W-1:0]   d_ext;
   logic [SCL_W-1:0]   b_ext;
   logic [NUM_W-1:0]   p_ext;
   logic               out_free;

   iclm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign d_ext = SCL_W'(delta_ff);
   assign b_ext = SCL_W'(baseline_ff);
   assign p_ext = NUM_W'(delta_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign ring_wr   = (state_ff == S_RING);

   // divider is shared by the busy quotient and the ring mean
   always_comb begin
      div_req.start = 1'b0;
      div_req.numer = prod_ff;
      div_req.denom = baseline_ff;
      if (state_ff == S_CLASS) begin
         div_req.start = (delta_ff < baseline_ff);
      end else if (state_ff == S_DIVA) begin
         div_req.start = 1'b1;
         div_req.numer = NUM_W'(acc_ff);
         div_req.denom = DATA_W'(AVG_WINDOWS);
      end
   end

   // ring storage with registered read
   always_ff @(posedge clock) begin
      if (ring_wr) begin
         ring_mem[pos_ff] <= busy_ff[HIST_W-1:0];
      end
      rd_ff <= ring_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         baseline_ff  <= '0;
         instant_ff   <= PCT_NONE;
         average_ff   <= PCT_NONE;
         windows_ff   <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the final step reloads the result register itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  delta_ff   <= req_idle_delta;
                  windows_ff <= windows_ff + 1'b1;
                  state_ff   <= S_SCALE;
               end
            end
            S_SCALE: begin
               // constant multiplies as shift-add
               sdelta_ff <= (d_ext << 4) + (d_ext << 2);
               sbase_ff  <= (b_ext << 4) + (b_ext << 2) + b_ext;
               prod_ff   <= (p_ext << 6) + (p_ext << 5) + (p_ext << 2);
               state_ff  <= S_CHECK;
            end
            S_CHECK: begin
               if (baseline_ff == '0 && delta_ff != '0) begin
                  // seeding window
                  baseline_ff <= delta_ff;
                  state_ff    <= S_EMIT;
               end else if (baseline_ff == '0) begin
                  // idle never ran
                  instant_ff <= PCT_FULL;
                  state_ff   <= S_EMIT;
               end else begin
                  // delta above baseline plus one twentieth, floor included
                  if (sdelta_ff > sbase_ff) begin
                     baseline_ff <= delta_ff;
                  end
                  state_ff <= S_CLASS;
               end
            end
            S_CLASS: begin
               if (delta_ff >= baseline_ff) begin
                  busy_ff  <= '0;
                  state_ff <= S_RING;
               end else begin
                  state_ff <= S_DIVQ;
               end
            end
            S_DIVQ: begin
               if (div_rsp.done) begin
                  busy_ff  <= PCT_FULL - PCT_W'(div_rsp.quotient);
                  state_ff <= S_RING;
               end
            end
            S_RING: begin
               instant_ff <= busy_ff;
               pos_ff     <= (pos_ff == IDX_W'(AVG_WINDOWS - 1)) ? '0 : pos_ff + 1'b1;
               if (fill_ff < CNT_W'(AVG_WINDOWS)) begin
                  fill_ff <= fill_ff + 1'b1;
               end
               idx_ff <= '0;
               acc_ff <= '0;
               if (fill_ff >= CNT_W'(AVG_WINDOWS - 1)) begin
                  state_ff <= S_SUM;
               end else begin
                  average_ff <= PCT_NONE;
                  state_ff   <= S_EMIT;
               end
            end
            S_SUM: begin
               // read of entry idx lands in the next cycle
               if (idx_ff != '0) begin
                  acc_ff <= acc_ff + SUM_W'(rd_ff);
               end
               if (idx_ff == IDX_W'(AVG_WINDOWS - 1)) begin
                  state_ff <= S_SUMEND;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_SUMEND: begin
               acc_ff   <= acc_ff + SUM_W'(rd_ff);
               idx_ff   <= '0;
               state_ff <= S_DIVA;
            end
            S_DIVA: begin
               state_ff <= S_DIVAW;
            end
            S_DIVAW: begin
               if (div_rsp.done) begin
                  average_ff <= PCT_W'(div_rsp.quotient);
                  state_ff   <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_instant_ff <= instant_ff;
                  rsp_average_ff <= average_ff;
                  rsp_total_ff   <= windows_ff;
                  rsp_ref_ff     <= baseline_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_load_instant   = rsp_instant_ff;
   assign rsp_load_average   = rsp_average_ff;
   assign rsp_window_total   = rsp_total_ff;
   assign rsp_idle_reference = rsp_ref_ff;

   // fill count saturates at the ring depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(AVG_WINDOWS))
      else $error("ring fill beyond depth");

   // a beat taken closes the input until its result is built
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input open while a beat is in work");

   // divider only finishes while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIVQ || state_ff == S_DIVAW))
      else $error("divider result with nobody waiting");

   // divider is never restarted in the middle of a division
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // percentages stay in range or carry the not-yet marker
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_load_instant <= PCT_FULL || rsp_load_instant == PCT_NONE) &&
                     (rsp_load_average <= PCT_FULL || rsp_load_average == PCT_NONE)))
      else $error("percentage out of range");

endmodule

[design/iclm_div.sv]
// iterative restoring divider, one quotient bit per cycle, quotient below 2^QUO_W
`timescale 1ns / 1ps

module iclm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  iclm_pkg::div_req_type req,
   output iclm_pkg::div_rsp_type rsp
);
   import iclm_pkg::*;

   localparam int unsigned CNT_W = $clog2(QUO_W + 1);

   logic [DATA_W-1:0] rem_ff;
   logic [QUO_W-1:0]  low_ff;   // numerator low bits shift out, quotient bits shift in
   logic [DATA_W-1:0] den_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [DATA_W:0]   trial;
   logic [DATA_W+1:0] diff;
   logic              fits;

   // shared subtract and compare
   assign trial = {rem_ff, low_ff[QUO_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, den_ff};
   assign fits  = ~diff[DATA_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            rem_ff  <= req.numer[NUM_W-1:QUO_W];
            low_ff  <= req.numer[QUO_W-1:0];
            den_ff  <= req.denom;
            cnt_ff  <= CNT_W'(QUO_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            low_ff <= {low_ff[QUO_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = low_ff;

endmodule

[verif/testbench.sv]
// self-checking testbench for the idle-count cpu load meter core
`timescale 1ns / 1ps

module testbench;
   import iclm_pkg::*;

   localparam int unsigned NUM_WIN  = 10;   // windows averaged by the ring
   localparam int unsigned N_RANDOM = 880;  // random windows after the directed ones
   localparam int unsigned N_HIGH   = 220;  // tail of the random part run at a huge baseline
   localparam int unsigned MAX_GAP  = 17;   // longest idle stretch on either side
   localparam int unsigned DRAIN    = 60;   // cycles allowed after the last result
   localparam logic [DATA_W-1:0] DELTA_MAX = '1;

   // one result beat as the block reports it
   typedef struct packed {
      logic [PCT_W-1:0]  load_instant;
      logic [PCT_W-1:0]  load_average;
      logic [DATA_W-1:0] window_total;
      logic [DATA_W-1:0] idle_reference;
   } load_report_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [DATA_W-1:0] req_idle_delta = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [PCT_W-1:0]  rsp_load_instant;
   logic [PCT_W-1:0]  rsp_load_average;
   logic [DATA_W-1:0] rsp_window_total;
   logic [DATA_W-1:0] rsp_idle_reference;

   idle_count_cpu_load_meter_core #(
      .AVG_WINDOWS(NUM_WIN)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_idle_delta(req_idle_delta),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_load_instant(rsp_load_instant),
      .rsp_load_average(rsp_load_average),
      .rsp_window_total(rsp_window_total),
      .rsp_idle_reference(rsp_idle_reference)
   );

   // 20 ns clock, reset held high at the start of the run
   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor state: our own copy of the meter
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] idle_base   = '0;
   logic [PCT_W-1:0]  pct_now     = PCT_NONE;
   logic [PCT_W-1:0]  pct_mean    = PCT_NONE;
   logic [DATA_W-1:0] window_cnt  = '0;
   logic [HIST_W-1:0] busy_hist [NUM_WIN];
   int unsigned       hist_wr     = 0;
   int unsigned       hist_cnt    = 0;

   // run statistics for the summary
   int unsigned       n_computed  = 0;
   int unsigned       n_recal     = 0;
   int unsigned       n_no_idle   = 0;
   int unsigned       n_full_avg  = 0;

   load_report_type   expected_reports [$];
   logic [DATA_W-1:0] delta_queue [$];
   logic [DATA_W-1:0] plan_base = '0;   // baseline as the stimulus builder tracks it

   int unsigned       n_items  = 0;
   int unsigned       accepted = 0;
   int unsigned       checked  = 0;
   int unsigned       errors   = 0;

   // advance the meter by one window and return what it should report
   function automatic load_report_type meter_predict(input logic [DATA_W-1:0] delta);
      logic [DATA_W:0]   limit;
      logic [63:0]       scaled;
      logic [63:0]       quot;
      logic [PCT_W-1:0]  busy;
      int unsigned       sum;
      load_report_type   rpt;
      window_cnt = window_cnt + 1'b1;
      if (idle_base == '0 && delta != '0) begin
         // seeding window: only the baseline and the count move
         idle_base = delta;
      end else begin
         // threshold formed one bit wider so a huge baseline cannot wrap it
         limit = {1'b0, idle_base} + {1'b0, idle_base / 20};
         if ({1'b0, delta} > limit) begin
            idle_base = delta;
            n_recal++;
         end
         if (idle_base == '0) begin
            // idle loop never ran: full load, ring untouched
            pct_now = PCT_FULL;
            n_no_idle++;
         end else begin
            if (delta >= idle_base) begin
               busy = '0;
            end else begin
               scaled = 64'(delta) * 64'd100;
               quot   = scaled / 64'(idle_base);
               busy   = PCT_FULL - quot[PCT_W-1:0];
            end
            pct_now = busy;
            busy_hist[hist_wr] = busy[HIST_W-1:0];
            hist_wr = (hist_wr == NUM_WIN - 1) ? 0 : hist_wr + 1;
            if (hist_cnt < NUM_WIN) hist_cnt++;
            if (hist_cnt >= NUM_WIN) begin
               sum = 0;
               for (int i = 0; i < NUM_WIN; i++) sum += busy_hist[i];
               pct_mean = PCT_W'(sum / NUM_WIN);
               n_full_avg++;
            end else begin
               pct_mean = PCT_NONE;
            end
            n_computed++;
         end
      end
      rpt.load_instant   = pct_now;
      rpt.load_average   = pct_mean;
      rpt.window_total   = window_cnt;
      rpt.idle_reference = idle_base;
      return rpt;
   endfunction

   // queue one window and track the baseline it leaves behind
   task automatic queue_delta(input logic [DATA_W-1:0] d);
      logic [DATA_W:0] limit;
      limit = {1'b0, plan_base} + {1'b0, plan_base / 20};
      if (plan_base == '0 && d != '0) plan_base = d;
      else if ({1'b0, d} > limit) plan_base = d;
      delta_queue.push_back(d);
   endtask

   // pick one random window relative to the current baseline
   function automatic logic [DATA_W-1:0] pick_delta(input logic [DATA_W-1:0] b,
                                                     input bit high_phase);
      logic [DATA_W+1:0] thr;
      logic [DATA_W+1:0] cand;
      int unsigned       roll;
      roll = $urandom_range(0, 99);
      thr  = {2'b00, b} + {2'b00, b / 20};
      if (roll < 6) begin
         cand = '0;
      end else if (roll < 14) begin
         // recalibration, or a value from the baseline up to the highest when the threshold is out of reach
         if (thr >= {2'b00, DELTA_MAX}) begin
            cand = {2'b00, b} + $urandom_range(0, DELTA_MAX - b);
         end else begin
            cand = thr + 1 + $urandom_range(0, b / 4 + 3);
         end
      end else if (roll < 24) begin
         // above the baseline but inside the tolerance band, or the baseline itself when the band is empty
         if (thr > {2'b00, b}) cand = {2'b00, b} + 1 + $urandom_range(0, b / 20 - 1);
         else cand = {2'b00, b};
      end else if (roll < 28) begin
         cand = {2'b00, b};
      end else if (high_phase && roll < 32) begin
         cand = {2'b00, DELTA_MAX};
      end else if (high_phase && roll < 37) begin
         cand = {2'b00, $urandom()};
      end else begin
         cand = {2'b00, 32'($urandom_range(0, b))};
      end
      if (cand > {2'b00, DELTA_MAX}) cand = {2'b00, DELTA_MAX};
      return cand[DATA_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // stimulus build, end of run
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < NUM_WIN; i++) busy_hist[i] = '0;

      // idle never ran twice, then a tiny seed where baseline/20 is zero
      queue_delta(32'd0);
      queue_delta(32'd0);
      queue_delta(32'd19);
      queue_delta(32'd19);   // equal to baseline
      queue_delta(32'd20);   // just past a zero-width band
      queue_delta(32'd21);   // inside the band at baseline 20
      queue_delta(32'd0);    // fully busy
      queue_delta(32'd1);
      queue_delta(32'd13);
      queue_delta(32'd19);
      queue_delta(32'd22);   // recalibration
      queue_delta(32'd11);
      queue_delta(32'd21);
      queue_delta(32'd1);    // ring is already full here
      queue_delta(32'd0);
      queue_delta(32'd5);
      queue_delta(32'd22);
      queue_delta(32'd17);
      queue_delta(32'd23);   // inside the band at baseline 22

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM - N_HIGH) begin
            // jump to a baseline whose tolerance band runs past the 32-bit range
            queue_delta(32'hF400_0000 + $urandom_range(0, 32'h0A00_0000));
         end else begin
            queue_delta(pick_delta(plan_base, i >= N_RANDOM - N_HIGH));
         end
      end
      n_items = delta_queue.size();

      wait (accepted == n_items && checked == n_items);
      repeat (DRAIN) @(posedge clock);
      if (expected_reports.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_reports.size());
         errors++;
      end
      $display("windows sent %0d, loads computed %0d, full averages %0d", accepted,
               n_computed, n_full_avg);
      $display("baseline updates %0d, idle-never-ran windows %0d, final baseline %0d",
               n_recal, n_no_idle, idle_base);
      if (errors == 0) begin
         $display("idle_count_cpu_load_meter_core: match");
      end else begin
         $display("idle_count_cpu_load_meter_core: mismatch");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #20_000_000;
      $display("%0t: timeout, %0d of %0d windows checked", $time, checked, n_items);
      $display("idle_count_cpu_load_meter_core: mismatch");
      $finish;
   end

   // ------------------------------------------------------------------
   // driver: one window per beat, random gap before each
   // ------------------------------------------------------------------
   int unsigned req_pause = 0;
   bit          req_calm  = 1'b0;   // stretch with no gaps

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_pause <= $urandom_range(0, MAX_GAP);
      end else begin
         if (req_valid && req_ready) begin
            expected_reports.push_back(meter_predict(req_idle_delta));
            accepted++;
         end
         // slot is free after this edge unless a beat is still waiting
         if (!req_valid || req_ready) begin
            if (req_pause != 0 || delta_queue.size() == 0) begin
               req_valid <= 1'b0;
               if (req_pause != 0) req_pause <= req_pause - 1;
            end else begin
               req_valid      <= 1'b1;
               req_idle_delta <= delta_queue.pop_front();
               if ($urandom_range(0, 39) == 0) req_calm <= ~req_calm;
               req_pause <= req_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: random stall before each result, check against the oldest expectation
   // ------------------------------------------------------------------
   int unsigned     rsp_stall = 0;
   int unsigned     rsp_next  = 0;
   bit              rsp_calm  = 1'b0;
   load_report_type want;

   task automatic compare_field(input string fname, input logic [DATA_W-1:0] exp_v,
                                input logic [DATA_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: window %0d %s expected %0d got %0d", $time, checked + 1, fname,
                  exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= $urandom_range(0, MAX_GAP);
      end else if (rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: result with nothing expected, instant %0d average %0d",
                     $time, rsp_load_instant, rsp_load_average);
            errors++;
         end else begin
            want = expected_reports.pop_front();
            compare_field("load_instant", DATA_W'(want.load_instant), DATA_W'(rsp_load_instant));
            compare_field("load_average", DATA_W'(want.load_average), DATA_W'(rsp_load_average));
            compare_field("window_total", want.window_total, rsp_window_total);
            compare_field("idle_reference", want.idle_reference, rsp_idle_reference);
         end
         checked++;
         if ($urandom_range(0, 39) == 0) rsp_calm <= ~rsp_calm;
         rsp_next = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
         // ready stays high when no stall is drawn, so it is assigned once
         if (rsp_next == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            rsp_stall <= rsp_next - 1;
         end
      end else if (!rsp_ready) begin
         if (rsp_stall == 0) rsp_ready <= 1'b1;
         else rsp_stall <= rsp_stall - 1;
      end
   end

endmodule

[filelist.f]
design/iclm_pkg.sv
design/iclm_div.sv
design/idle_count_cpu_load_meter_core.sv
verif/testbench.sv
